[src/aging_page_replacement_defines.svh]
// assertion macros for the aging page replacement block
`ifndef AGING_PAGE_REPLACEMENT_DEFINES_SVH
`define AGING_PAGE_REPLACEMENT_DEFINES_SVH
`ifndef SYNTHESIS
`define APR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("apr assertion failed");
`define APR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("apr assertion failed");
`else
`define APR_ASSERT_IMP(lbl, ante, cons)
`define APR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/apr_pkg.sv]
// types and constants shared by the aging page replacement block
package apr_pkg;
    localparam int FRAMES_DEF = 16;
    localparam int PAGES_DEF = 2048;
    localparam int HISTORY_BITS_DEF = 8;
    localparam int PAGE_IN_W = 11;
    localparam int CFG_W = 16;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 120;
    localparam logic [4:0] FRAMES_IN_USE_RST = 5'd16;
    localparam logic [15:0] AGING_INTERVAL_RST = 16'd30;
    localparam logic REG_FRAMES_IN_USE = 1'b0;
    localparam logic REG_AGING_INTERVAL = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_MOD, ST_RDREF, ST_WRREF, ST_LOOK,
        ST_VREAD, ST_VCMP, ST_UPDATE, ST_AGE, ST_DONE
    } apr_state_t;
endpackage

[src/aging_page_replacement.sv]
// aging page replacement: top level with frame table, sequencer and history memory
//
// Input words arrive on s_tdata (page, dirty flag) and one result word leaves on
// m_tdata for each. Registers are written on the cfg port, index 0 frames_in_use,
// index 1 aging_interval; the user must write them only while the block is idle,
// which the block itself does not enforce. An item passes page reduction, a
// history read and write, a frame lookup that stops at a hit, a victim search over
// the active frames on a miss with no free frame, the table update, an aging
// shift over every page when the aging interval is reached, and the loading of the
// result. Lookup and victim search visit one frame at a time through the single
// frame comparator and the history memory port. After reset the history memory is
// cleared while s_tready stays low; configuration writes are taken as ever.
// The result sits in an output register; a new word is accepted while it waits,
// and the sequencer holds at its last step until m_tready frees the register.
module aging_page_replacement
    import apr_pkg::*;
#(
    parameter int FRAMES = apr_pkg::FRAMES_DEF,
    parameter int PAGES = apr_pkg::PAGES_DEF,
    parameter int HISTORY_BITS = apr_pkg::HISTORY_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic                          cfg_index,
    input  logic [apr_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // page[10:0], dirty[11], zero fill
    input  logic [apr_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit[0], fault[1], needs_write_back[2], frame_index[6:3], evicted_valid[7],
    // evicted_page[18:8], history_shifted[19], fault_count[51:20],
    // write_back_count[83:52], shift_count[115:84], zero fill
    output logic [apr_pkg::OUT_TDATA_W-1:0] m_tdata
);
    `include "aging_page_replacement_defines.svh"

    localparam int FR_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FRC_W = $clog2(FRAMES + 1);
    localparam int PAGE_W = $clog2(PAGES);
    localparam int WORD_W = HISTORY_BITS + 1;

    apr_state_t state_reg, state_next;

    logic [4:0]  fiu_reg;
    logic [15:0] interval_reg;

    logic [PAGE_IN_W-1:0] frame_page_reg [FRAMES];
    logic [FRAMES-1:0]    frame_valid_reg;
    logic [FRAMES-1:0]    frame_dirty_reg;
    logic [31:0]          frame_time_reg [FRAMES];

    logic [PAGE_IN_W-1:0]    page_reg, page_next;
    logic                    dirty_reg, dirty_next;
    logic                    hit_reg, hit_next;
    logic                    found_reg, found_next;
    logic [FR_W-1:0]         slot_reg, slot_next;
    logic [FR_W-1:0]         f_reg, f_next;
    logic [HISTORY_BITS-1:0] best_h_reg, best_h_next;
    logic [31:0]             best_t_reg, best_t_next;
    logic [PAGE_W:0]         cnt_reg, cnt_next;
    logic                    shifted_reg;
    logic                    wb_reg;
    logic                    ev_reg;
    logic [PAGE_IN_W-1:0]    ev_page_reg;
    logic [31:0]             refidx_reg, faults_reg, wbs_reg, shifts_reg;
    logic [15:0]             phase_reg;

    logic                    out_valid_reg;
    logic [OUT_TDATA_W-1:0]  out_data_reg;

    logic                    ram_we;
    logic [PAGE_W-1:0]       ram_waddr, ram_raddr;
    logic [WORD_W-1:0]       ram_wdata, ram_rdata;

    logic [FRC_W-1:0]        n_active;
    logic [15:0]             interval_eff;
    logic [15:0]             phase_cur;
    logic [16:0]             phase_inc;
    logic                    s_accept;
    logic                    out_free;
    logic                    look_hit, look_empty, look_last;
    logic                    v_better;
    logic [HISTORY_BITS-1:0] v_hist;
    logic                    ev_now;

    apr_ram #(.WIDTH(WORD_W), .DEPTH(PAGES)) u_hist_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign n_active = (fiu_reg == 5'd0) ? FRC_W'(1)
                    : (int'(fiu_reg) > FRAMES) ? FRC_W'(FRAMES) : FRC_W'(fiu_reg);
    assign interval_eff = (interval_reg == 16'd0) ? 16'd1 : interval_reg;
    assign phase_cur = (phase_reg >= interval_eff) ? 16'd0 : phase_reg;
    assign phase_inc = {1'b0, phase_cur} + 17'd1;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign look_hit   = frame_valid_reg[f_reg] && (frame_page_reg[f_reg] == page_reg);
    assign look_empty = !frame_valid_reg[f_reg];
    assign look_last  = (int'(f_reg) == int'(n_active) - 1);

    assign v_hist   = ram_rdata[HISTORY_BITS:1];
    assign v_better = (f_reg == '0) || (v_hist < best_h_reg)
                   || ((v_hist == best_h_reg) && (frame_time_reg[f_reg] < best_t_reg));
    assign ev_now   = !hit_reg && !found_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (int'(cnt_reg) == PAGES - 1) state_next = ST_IDLE;
            ST_IDLE:   if (s_accept) state_next = ST_MOD;
            ST_MOD:    if (int'(page_reg) < PAGES) state_next = ST_RDREF;
            ST_RDREF:  state_next = ST_WRREF;
            ST_WRREF:  state_next = ST_LOOK;
            ST_LOOK: begin
                if (look_hit) begin
                    state_next = ST_UPDATE;
                end else if (look_last) begin
                    state_next = (found_reg || look_empty) ? ST_UPDATE : ST_VREAD;
                end
            end
            ST_VREAD:  state_next = ST_VCMP;
            ST_VCMP:   state_next = look_last ? ST_UPDATE : ST_VREAD;
            ST_UPDATE: state_next = (phase_cur == 16'd0) ? ST_AGE : ST_DONE;
            ST_AGE:    if (int'(cnt_reg) == PAGES) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer datapath and memory port
    always_comb begin
        page_next   = page_reg;
        dirty_next  = dirty_reg;
        hit_next    = hit_reg;
        found_next  = found_reg;
        slot_next   = slot_reg;
        f_next      = f_reg;
        best_h_next = best_h_reg;
        best_t_next = best_t_reg;
        cnt_next    = cnt_reg;
        ram_we      = 1'b0;
        ram_waddr   = PAGE_W'(page_reg);
        ram_wdata   = '0;
        ram_raddr   = PAGE_W'(page_reg);
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[PAGE_W-1:0];
                cnt_next  = cnt_reg + 1'b1;
            end
            ST_IDLE: begin
                page_next  = s_tdata[PAGE_IN_W-1:0];
                dirty_next = s_tdata[PAGE_IN_W];
                hit_next   = 1'b0;
                found_next = 1'b0;
                f_next     = '0;
            end
            ST_MOD: begin
                if (int'(page_reg) >= PAGES) page_next = page_reg - PAGE_IN_W'(PAGES);
            end
            ST_WRREF: begin
                ram_we    = 1'b1;
                ram_wdata = {ram_rdata[HISTORY_BITS:1], 1'b1};
            end
            ST_LOOK: begin
                if (look_hit) begin
                    hit_next  = 1'b1;
                    slot_next = f_reg;
                end else begin
                    if (look_empty && !found_reg) begin
                        found_next = 1'b1;
                        slot_next  = f_reg;
                    end
                    f_next = look_last ? '0 : f_reg + 1'b1;
                end
            end
            ST_VREAD: begin
                ram_raddr = PAGE_W'(frame_page_reg[f_reg]);
            end
            ST_VCMP: begin
                if (v_better) begin
                    slot_next   = f_reg;
                    best_h_next = v_hist;
                    best_t_next = frame_time_reg[f_reg];
                end
                f_next = f_reg + 1'b1;
            end
            ST_UPDATE: cnt_next = '0;
            ST_AGE: begin
                ram_raddr = cnt_reg[PAGE_W-1:0];
                ram_we    = (cnt_reg != '0);
                ram_waddr = PAGE_W'(cnt_reg - 1'b1);
                ram_wdata = {ram_rdata[0], ram_rdata[HISTORY_BITS:2], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
            end
            ST_RDREF, ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        page_reg   <= page_next;
        dirty_reg  <= dirty_next;
        hit_reg    <= hit_next;
        found_reg  <= found_next;
        slot_reg   <= slot_next;
        f_reg      <= f_next;
        best_h_reg <= best_h_next;
        best_t_reg <= best_t_next;
        if (state_reg == ST_UPDATE) begin
            ev_reg      <= ev_now;
            wb_reg      <= ev_now && frame_dirty_reg[slot_reg];
            ev_page_reg <= ev_now ? frame_page_reg[slot_reg] : '0;
            shifted_reg <= (phase_cur == 16'd0);
            if (!hit_reg) begin
                frame_page_reg[slot_reg] <= page_reg;
                frame_time_reg[slot_reg] <= refidx_reg;
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            out_data_reg <= {4'd0, shifts_reg, wbs_reg, faults_reg, shifted_reg,
                             ev_page_reg, ev_reg, 4'(slot_reg), wb_reg, !hit_reg, hit_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            cnt_reg         <= '0;
            fiu_reg         <= FRAMES_IN_USE_RST;
            interval_reg    <= AGING_INTERVAL_RST;
            frame_valid_reg <= '0;
            frame_dirty_reg <= '0;
            refidx_reg      <= '0;
            faults_reg      <= '0;
            wbs_reg         <= '0;
            shifts_reg      <= '0;
            phase_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_wen) begin
                unique case (cfg_index)
                    REG_FRAMES_IN_USE:  fiu_reg <= cfg_wdata[4:0];
                    REG_AGING_INTERVAL: interval_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (state_reg == ST_UPDATE) begin
                if (hit_reg) begin
                    frame_dirty_reg[slot_reg] <= frame_dirty_reg[slot_reg] | dirty_reg;
                end else begin
                    frame_valid_reg[slot_reg] <= 1'b1;
                    frame_dirty_reg[slot_reg] <= dirty_reg;
                    if (faults_reg != '1) faults_reg <= faults_reg + 1'b1;
                    if (ev_now && frame_dirty_reg[slot_reg] && wbs_reg != '1) begin
                        wbs_reg <= wbs_reg + 1'b1;
                    end
                end
                if (phase_cur == 16'd0 && shifts_reg != '1) shifts_reg <= shifts_reg + 1'b1;
                phase_reg  <= (phase_inc >= {1'b0, interval_eff}) ? 16'd0 : phase_inc[15:0];
                refidx_reg <= refidx_reg + 1'b1;
            end
            if (state_reg == ST_DONE && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `APR_ASSERT_NEXT(a_accept_starts, s_accept, state_reg == ST_MOD)
    `APR_ASSERT_IMP(a_clear_blocks, state_reg == ST_CLEAR, !s_tready)
    `APR_ASSERT_IMP(a_evict_is_miss, m_tvalid && m_tdata[7], !m_tdata[0] && m_tdata[1])
endmodule

[src/apr_ram.sv]
// generic memory, one write port and one registered read port
module apr_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
